// File: hdl/msd_pkg.sv
// Shared types, constants and helper functions for the Morse unit stream decoder.
// Used by msd_front, msd_queue, msd_back and the top level; depends on nothing.
package msd_pkg;

  localparam int LETTERS = 26;

  localparam logic [6:0] CHAR_A     = 7'd65;
  localparam logic [6:0] CHAR_SPACE = 7'd32;

  // Element count value that marks an over-long letter
  localparam logic [2:0] OVERFLOW_COUNT = 3'd5;
  localparam logic [2:0] MAX_ELEMENTS   = 3'd4;

  localparam logic [4:0] MARK_RUN_MAX = 5'd31;
  localparam logic [3:0] GAP_RUN_MAX  = 4'd15;

  // Configuration register indexes
  localparam logic [1:0] REG_DASH_UNITS       = 2'd0;
  localparam logic [1:0] REG_LETTER_GAP_UNITS = 2'd1;
  localparam logic [1:0] REG_WORD_GAP_UNITS   = 2'd2;

  localparam logic [3:0] DASH_UNITS_RESET       = 4'd3;
  localparam logic [3:0] LETTER_GAP_UNITS_RESET = 4'd3;
  localparam logic [3:0] WORD_GAP_UNITS_RESET   = 4'd7;

  // Letter table: element count in bits 6..4, pattern in bits 3..0 (1 dash, 0 dot)
  localparam logic [6:0] LETTER_ROM [LETTERS] = '{
    7'h22, 7'h41, 7'h45, 7'h31, 7'h10, 7'h44, 7'h33, 7'h40, 7'h20, 7'h4E,
    7'h35, 7'h42, 7'h23, 7'h21, 7'h37, 7'h46, 7'h4B, 7'h32, 7'h30, 7'h11,
    7'h34, 7'h48, 7'h36, 7'h49, 7'h4D, 7'h43
  };

  typedef struct packed {
    logic [2:0] count;
    logic [3:0] bits;
  } elem_t;

  typedef struct packed {
    logic       found;
    logic [6:0] ch;
  } lookup_t;

  // One queue entry: one or two characters caused by a single input unit
  typedef struct packed {
    logic       pair;
    logic [6:0] ch0;
    logic [6:0] ch1;
  } rec_t;

  // Close a mark run into the collected elements
  function automatic elem_t close_run(elem_t e, logic [4:0] run, logic [3:0] dash_units);
    elem_t r;
    logic  is_dash;
    logic  is_dot;
    r       = e;
    is_dash = (run == {1'b0, dash_units});
    is_dot  = (run == 5'd1);
    if (run != 5'd0 && (is_dash || is_dot)) begin
      if (e.count < MAX_ELEMENTS) begin
        r.bits  = e.bits | (4'(is_dash) << e.count[1:0]);
        r.count = e.count + 3'd1;
      end else begin
        r.count = OVERFLOW_COUNT;
      end
    end
    return r;
  endfunction

  // Match the collected elements against the letter table
  function automatic lookup_t lookup_letter(elem_t e);
    lookup_t    r;
    logic [6:0] key;
    r.found = 1'b0;
    r.ch    = CHAR_A;
    key     = {e.count, e.bits};
    if (e.count >= 3'd1 && e.count <= MAX_ELEMENTS) begin
      for (int a = 0; a < LETTERS; a++) begin
        if (LETTER_ROM[a] == key) begin
          r.found = 1'b1;
          r.ch    = CHAR_A + 7'(a);
        end
      end
    end
    return r;
  endfunction

endpackage

// File: hdl/msd_front.sv
// Front end: configuration registers, run counters and element collection.
// Classifies each accepted unit and produces a queue entry; uses msd_pkg.
module msd_front
  import msd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic       kind,
  input  logic       message_end,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [3:0] cfg_data,
  output logic       rec_push,
  output rec_t       rec
);

  logic [3:0] dash_units;
  logic [3:0] letter_gap_units;
  logic [3:0] word_gap_units;

  logic [4:0] mark_run;
  logic [3:0] gap_run;
  elem_t      elems;

  logic [4:0] mark_run_next;
  logic [3:0] gap_run_next;
  elem_t      elems_next;

  always_comb begin
    elem_t      e_kept;
    elem_t      e_mark_close;
    elem_t      e_gap_close;
    lookup_t    lk_orig;
    lookup_t    lk_mark;
    lookup_t    lk_gap;
    logic       letter_due;
    logic       word_due;
    logic [4:0] mark_inc;
    logic [3:0] gap_inc;
    logic       a_v;
    logic       b_v;
    logic [6:0] a_ch;
    logic [6:0] b_ch;

    mark_inc     = (mark_run < MARK_RUN_MAX) ? mark_run + 5'd1 : mark_run;
    gap_inc      = (gap_run < GAP_RUN_MAX) ? gap_run + 4'd1 : gap_run;
    letter_due   = (gap_run == letter_gap_units);
    word_due     = (gap_inc == word_gap_units);

    // mark path: letter before the mark, then a possible flush at message end
    lk_orig      = lookup_letter(elems);
    e_kept       = letter_due ? '0 : elems;
    e_mark_close = close_run(e_kept, mark_inc, dash_units);
    lk_mark      = lookup_letter(e_mark_close);

    // gap path: the mark run closes as the gap starts
    e_gap_close  = close_run(elems, mark_run, dash_units);
    lk_gap       = lookup_letter(e_gap_close);

    if (!kind) begin
      a_v           = letter_due && lk_orig.found;
      a_ch          = lk_orig.ch;
      b_v           = message_end && lk_mark.found;
      b_ch          = lk_mark.ch;
      mark_run_next = mark_inc;
      gap_run_next  = 4'd0;
      elems_next    = e_kept;
    end else begin
      a_v           = (word_due || message_end) && lk_gap.found;
      a_ch          = lk_gap.ch;
      b_v           = word_due;
      b_ch          = CHAR_SPACE;
      mark_run_next = 5'd0;
      gap_run_next  = word_due ? 4'd0 : gap_inc;
      elems_next    = word_due ? '0 : e_gap_close;
    end

    if (message_end) begin
      mark_run_next = 5'd0;
      gap_run_next  = 4'd0;
      elems_next    = '0;
    end

    rec_push = accept && (a_v || b_v);
    rec.pair = a_v && b_v;
    rec.ch0  = a_v ? a_ch : b_ch;
    rec.ch1  = b_ch;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dash_units       <= DASH_UNITS_RESET;
      letter_gap_units <= LETTER_GAP_UNITS_RESET;
      word_gap_units   <= WORD_GAP_UNITS_RESET;
      mark_run         <= 5'd0;
      gap_run          <= 4'd0;
      elems            <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DASH_UNITS:       dash_units       <= cfg_data;
          REG_LETTER_GAP_UNITS: letter_gap_units <= cfg_data;
          REG_WORD_GAP_UNITS:   word_gap_units   <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        mark_run <= mark_run_next;
        gap_run  <= gap_run_next;
        elems    <= elems_next;
      end
    end
  end

endmodule

// File: hdl/msd_queue.sv
// Short first-in first-out queue of entries between front and back end.
// Flip-flop storage, head entry read through the read pointer; uses msd_pkg.
module msd_queue
  import msd_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  rec_t wr_data,
  input  logic rd,
  output rec_t rd_data,
  output logic q_empty,
  output logic q_full
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  rec_t             store [DEPTH];
  logic [IDX_W-1:0] wr_ptr;
  logic [IDX_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign q_empty = (fill == CNT_W'(0));
  assign q_full  = (fill == CNT_W'(DEPTH));
  assign rd_data = store[rd_ptr];

  function automatic logic [IDX_W-1:0] wrap_inc(logic [IDX_W-1:0] p);
    return (p == IDX_W'(DEPTH - 1)) ? IDX_W'(0) : p + IDX_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr) wr_ptr <= wrap_inc(wr_ptr);
      if (rd) rd_ptr <= wrap_inc(rd_ptr);
      if (wr && !rd)      fill <= fill + CNT_W'(1);
      else if (rd && !wr) fill <= fill - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) store[wr_ptr] <= wr_data;
  end

endmodule

// File: hdl/msd_back.sv
// Back end: splits each queue entry into single results in an output register.
// Marks the final result of each entry; uses msd_pkg.
module msd_back
  import msd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       q_empty,
  input  rec_t       head,
  output logic       q_pop,
  input  logic       pop,
  output logic       empty,
  output logic [6:0] character,
  output logic       last_of_run
);

  logic       out_valid;
  logic       phase;
  logic       out_free;
  logic       load;
  logic       last_sel;
  logic [6:0] ch_sel;

  assign out_free = !out_valid || pop;
  assign load     = out_free && !q_empty;
  assign last_sel = phase || !head.pair;
  assign ch_sel   = phase ? head.ch1 : head.ch0;
  assign q_pop    = load && last_sel;
  assign empty    = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= 1'b0;
    end else begin
      if (out_free) out_valid <= !q_empty;
      if (load)     phase     <= !last_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      character   <= ch_sel;
      last_of_run <= last_sel;
    end
  end

endmodule

// File: hdl/morse_unit_stream_decoder.sv
// Top level of the Morse unit stream decoder: front end, entry queue, back end.
// Depends on msd_pkg, msd_front, msd_queue and msd_back.
//
//   channel   handshake            payload                   direction
//   ------    ---------            -------                   ---------
//   units     push / full          kind, message_end         in
//   results   pop / empty          character, last_of_run    out
//   config    cfg_we               cfg_index, cfg_data       in
//
// One unit is taken every cycle while full is low; the front end updates its
// counters and the letter lookup in that same cycle. A unit that causes two
// results (letter and space, or two letters at message end) holds the back end
// while it emits both, so the entry queue of QUEUE_DEPTH entries absorbs bursts.
// Results are loaded from the queue head into a registered output.
// Reset is synchronous: counters clear, registers return to 3, 3 and 7.
// full reflects only queue occupancy; a stalled pop backs up into the queue.
module morse_unit_stream_decoder
  import msd_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic       kind,
  input  logic       message_end,
  output logic       empty,
  input  logic       pop,
  output logic [6:0] character,
  output logic       last_of_run,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [3:0] cfg_data
);

  logic accept;
  logic rec_push;
  rec_t rec;
  rec_t head;
  logic q_pop;
  logic q_empty;
  logic q_full;

  // transfer on the unit channel only while the queue has room
  assign accept = push && !q_full;
  assign full   = q_full;

  msd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .kind        (kind),
    .message_end (message_end),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .rec_push    (rec_push),
    .rec         (rec)
  );

  // hold entries here while the result side stalls
  msd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (rec_push),
    .wr_data (rec),
    .rd      (q_pop),
    .rd_data (head),
    .q_empty (q_empty),
    .q_full  (q_full)
  );

  // advance one result per cycle into the output register while it is free or being popped
  msd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .head        (head),
    .q_pop       (q_pop),
    .pop         (pop),
    .empty       (empty),
    .character   (character),
    .last_of_run (last_of_run)
  );

endmodule

// File: tb/sv/morse_decode_checker.sv
`timescale 1ns / 1ps
// Checker for the Morse unit stream decoder: watches the unit, result and
// configuration ports, predicts the characters and compares them in order.
// Depends on msd_pkg for the register indexes and reset values.
module morse_decode_checker
  import msd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic       full,
  input  logic       kind,
  input  logic       message_end,
  input  logic       empty,
  input  logic       pop,
  input  logic [6:0] character,
  input  logic       last_of_run,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [3:0] cfg_data,
  output int         errors,
  output int         pending
);

  localparam logic [6:0] FIRST_LETTER = 7'h41;
  localparam logic [6:0] SPACE_CHAR   = 7'h20;
  localparam logic [2:0] FULL_LETTER  = 3'd4;
  localparam logic [2:0] TOO_LONG     = 3'd5;
  localparam logic [4:0] MARK_CEILING = 5'd31;
  localparam logic [3:0] GAP_CEILING  = 4'd15;

  typedef struct packed {
    logic [6:0] ch;
    logic       last;
  } char_rec_t;

  // Dots and dashes of A to Z, first element leftmost
  string code_book [26] = '{
    ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
    "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
    "..-", "...-", ".--", "-..-", "-.--", "--.."
  };

  char_rec_t  char_due [$];
  logic [6:0] fresh [$];

  logic [3:0] dash_len;
  logic [3:0] letter_gap;
  logic [3:0] word_gap;
  logic [4:0] mark_cnt;
  logic [3:0] gap_cnt;
  logic [3:0] elem_pat;
  logic [2:0] elem_num;

  task automatic report(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    errors++;
  endtask

  // Turn the finished mark run into a dot, a dash or nothing
  function automatic void close_mark();
    logic is_dash;
    is_dash = (mark_cnt == {1'b0, dash_len});
    if (mark_cnt != '0 && (is_dash || mark_cnt == 5'd1)) begin
      if (elem_num < FULL_LETTER) begin
        elem_pat[elem_num[1:0]] = is_dash;
        elem_num++;
      end else begin
        elem_num = TOO_LONG;
      end
    end
    mark_cnt = '0;
  endfunction

  // Look the collected elements up; drop anything that spells no letter
  function automatic void flush_letter();
    string code;
    logic  match;
    if (elem_num >= 3'd1 && elem_num <= FULL_LETTER) begin
      for (int a = 0; a < 26; a++) begin
        code  = code_book[a];
        match = (code.len() == int'(elem_num));
        for (int b = 0; b < code.len(); b++)
          if ((code[b] == "-") != elem_pat[b]) match = 1'b0;
        if (match) fresh.push_back(FIRST_LETTER + 7'(a));
      end
    end
    elem_pat = '0;
    elem_num = '0;
  endfunction

  function automatic void decode_unit(input logic is_gap, input logic ends);
    char_rec_t rec;
    fresh.delete();
    if (!is_gap) begin
      if (gap_cnt == letter_gap) flush_letter();
      gap_cnt = '0;
      if (mark_cnt != MARK_CEILING) mark_cnt++;
    end else begin
      close_mark();
      if (gap_cnt != GAP_CEILING) gap_cnt++;
      if (gap_cnt == word_gap) begin
        flush_letter();
        fresh.push_back(SPACE_CHAR);
        gap_cnt = '0;
      end
    end
    if (ends) begin
      close_mark();
      flush_letter();
      mark_cnt = '0;
      gap_cnt  = '0;
    end
    foreach (fresh[i]) begin
      rec.ch   = fresh[i];
      rec.last = (i == fresh.size() - 1);
      char_due.push_back(rec);
    end
  endfunction

  // Results first: a unit taken at this edge cannot have a result out yet
  always @(posedge clk) begin
    char_rec_t head;
    if (rst) begin
      dash_len   = DASH_UNITS_RESET;
      letter_gap = LETTER_GAP_UNITS_RESET;
      word_gap   = WORD_GAP_UNITS_RESET;
      mark_cnt   = '0;
      gap_cnt    = '0;
      elem_pat   = '0;
      elem_num   = '0;
      char_due.delete();
    end else begin
      if (pop && !empty) begin
        if (char_due.size() == 0) begin
          report($sformatf("character %0d with nothing due", character));
        end else begin
          head = char_due.pop_front();
          if (character !== head.ch)
            report($sformatf("character %0d, due %0d", character, head.ch));
          if (last_of_run !== head.last)
            report($sformatf("last_of_run %b, due %b (character %0d)",
                             last_of_run, head.last, head.ch));
        end
      end
      if (push && !full) decode_unit(kind, message_end);
      if (cfg_we) begin
        case (cfg_index)
          REG_DASH_UNITS:       dash_len   = cfg_data;
          REG_LETTER_GAP_UNITS: letter_gap = cfg_data;
          REG_WORD_GAP_UNITS:   word_gap   = cfg_data;
          default: ;
        endcase
      end
    end
    pending = char_due.size();
  end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// Testbench top for the Morse unit stream decoder: clock, reset, unit and
// register stimulus, result back-pressure and the verdict.
// Depends on msd_pkg, morse_unit_stream_decoder and morse_decode_checker.
module tb;
  import msd_pkg::*;

  localparam logic       UNIT_MARK       = 1'b0;
  localparam logic       UNIT_GAP        = 1'b1;
  localparam logic [1:0] REG_SPARE       = 2'd3;  // no register behind it
  localparam int         MAX_IDLE        = 13;
  localparam int         UNITS_PER_PHASE = 60;
  localparam int         SETTLE_CYCLES   = 6;
  localparam int         TIMEOUT_NS      = 5_000_000;

  // Letter endings for the keyed patterns
  localparam int END_LETTER_GAP = 0;
  localparam int END_WORD_GAP   = 1;
  localparam int END_MESSAGE    = 2;

  logic       clk;
  logic       rst;
  logic       push;
  logic       full;
  logic       kind;
  logic       message_end;
  logic       empty;
  logic       pop;
  logic [6:0] character;
  logic       last_of_run;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [3:0] cfg_data;

  int errors;
  int pending;
  int units_sent;

  // Busy stretches with no idling on either side, toggled now and then
  logic src_calm;
  logic sink_calm;

  // Timing the stimulus is shaped for; the checker keeps its own copy
  logic [3:0] dash_len;
  logic [3:0] letter_gap;
  logic [3:0] word_gap;

  morse_unit_stream_decoder DUT (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .kind        (kind),
    .message_end (message_end),
    .empty       (empty),
    .pop         (pop),
    .character   (character),
    .last_of_run (last_of_run),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  morse_decode_checker decode_check (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .kind        (kind),
    .message_end (message_end),
    .empty       (empty),
    .pop         (pop),
    .character   (character),
    .last_of_run (last_of_run),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .errors      (errors),
    .pending     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case a result never turns up or the block locks up
  initial begin
    #(TIMEOUT_NS);
    $display("Simulation FAILED");
    $finish;
  end

  // Result side: wait a drawn number of cycles, then hold pop until a
  // transfer happens. Inputs move on the falling edge only.
  initial begin : result_sink
    int idle;
    pop       = 1'b0;
    sink_calm = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) sink_calm = !sink_calm;
      idle = sink_calm ? 0 : $urandom_range(0, MAX_IDLE);
      if (idle > 0) begin
        pop <= 1'b0;
        repeat (idle) @(negedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      @(negedge clk);
    end
  end

  // Offer one unit after a drawn idle spell and hold it until it transfers.
  // push stays high across back-to-back units so it never drops and rises
  // within one step.
  task automatic send_unit(input logic unit_kind, input logic unit_end);
    int idle;
    if ($urandom_range(0, 39) == 0) src_calm = !src_calm;
    idle = src_calm ? 0 : $urandom_range(0, MAX_IDLE);
    @(negedge clk);
    if (idle > 0) begin
      push <= 1'b0;
      repeat (idle) @(negedge clk);
    end
    push        <= 1'b1;
    kind        <= unit_kind;
    message_end <= unit_end;
    do @(posedge clk); while (full);
    units_sent++;
  endtask

  task automatic send_run(input logic unit_kind, input int count, input logic end_on_last);
    for (int i = 0; i < count; i++)
      send_unit(unit_kind, end_on_last && i == count - 1);
  endtask

  // Drop push, wait for every due character, then let the block settle
  // before anything is reconfigured
  task automatic drain();
    @(negedge clk);
    push <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [3:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Write all three timing registers plus the unused index, which must
  // leave the decoder untouched
  task automatic set_timing(input logic [3:0] dash, input logic [3:0] letter,
                            input logic [3:0] word);
    write_reg(REG_DASH_UNITS, dash);
    write_reg(REG_LETTER_GAP_UNITS, letter);
    write_reg(REG_WORD_GAP_UNITS, word);
    write_reg(REG_SPARE, 4'($urandom()));
    dash_len   = dash;
    letter_gap = letter;
    word_gap   = word;
  endtask

  // Key a letter of n elements, bit e of pattern set for a dash. With a
  // zero dash length the dash run is keyed as two units and comes to nothing.
  task automatic key_pattern(input int n, input logic [5:0] pattern, input int ending);
    int  run;
    int  spacing;
    spacing = (letter_gap == 4'd1) ? 2 : 1;
    for (int e = 0; e < n; e++) begin
      if (e > 0) send_run(UNIT_GAP, spacing, 1'b0);
      run = !pattern[e] ? 1 : (dash_len != 4'd0) ? int'(dash_len) : 2;
      send_run(UNIT_MARK, run, ending == END_MESSAGE && e == n - 1);
    end
    case (ending)
      END_LETTER_GAP: send_run(UNIT_GAP, int'(letter_gap), 1'b0);
      END_WORD_GAP:   send_run(UNIT_GAP, (word_gap != 4'd0) ? int'(word_gap) : 9, 1'b0);
      default: ;
    endcase
  endtask

  // Mostly well-formed letters with random content, with stray units,
  // long mark runs and long gaps mixed in
  task automatic random_traffic(input int quota);
    int         first;
    int         pick;
    int         n;
    logic [5:0] pattern;
    first = units_sent;
    while (units_sent - first < quota) begin
      pick = $urandom_range(0, 9);
      if (pick <= 6) begin
        n       = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 6) : $urandom_range(1, 4);
        pattern = 6'($urandom());
        key_pattern(n, pattern, $urandom_range(END_LETTER_GAP, END_MESSAGE));
      end else if (pick == 7) begin
        n = $urandom_range(1, 20);
        repeat (n) send_unit(1'($urandom_range(0, 1)), $urandom_range(0, 7) == 0);
      end else if (pick == 8) begin
        send_run(UNIT_MARK, $urandom_range(2, 35), $urandom_range(0, 5) == 0);
      end else begin
        send_run(UNIT_GAP, $urandom_range(1, 18), $urandom_range(0, 3) == 0);
      end
    end
  endtask

  initial begin
    rst         = 1'b1;
    push        = 1'b0;
    kind        = UNIT_MARK;
    message_end = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = REG_DASH_UNITS;
    cfg_data    = '0;
    src_calm    = 1'b0;
    units_sent  = 0;
    dash_len    = DASH_UNITS_RESET;
    letter_gap  = LETTER_GAP_UNITS_RESET;
    word_gap    = WORD_GAP_UNITS_RESET;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // Directed, reset timing. Dot-dash, then a letter gap ended by a single
    // mark that also closes the message: A and E come from one unit.
    send_unit(UNIT_MARK, 1'b0);
    send_unit(UNIT_GAP, 1'b0);
    send_run(UNIT_MARK, 3, 1'b0);
    send_run(UNIT_GAP, 3, 1'b0);
    send_unit(UNIT_MARK, 1'b1);
    // Word gap with nothing collected: a lone space
    send_run(UNIT_GAP, 7, 1'b0);
    // Five dots overflow the letter, which is then dropped at message end
    repeat (4) begin
      send_unit(UNIT_MARK, 1'b0);
      send_unit(UNIT_GAP, 1'b0);
    end
    send_unit(UNIT_MARK, 1'b1);
    drain();

    // Random phases: reset timing, shortest gaps, dot-dash tie, equal
    // longest gaps, zero everywhere, two random settings, back to reset
    random_traffic(UNITS_PER_PHASE);
    drain();
    set_timing(4'd2, 4'd1, 4'd2);
    random_traffic(UNITS_PER_PHASE);
    drain();
    set_timing(4'd1, 4'd4, 4'd9);
    random_traffic(UNITS_PER_PHASE);
    drain();
    set_timing(4'd15, 4'd15, 4'd15);
    random_traffic(UNITS_PER_PHASE);
    drain();
    set_timing(4'd0, 4'd0, 4'd0);
    random_traffic(UNITS_PER_PHASE);
    drain();
    repeat (2) begin
      set_timing(4'($urandom_range(2, 6)), 4'($urandom_range(1, 5)),
                 4'($urandom_range(2, 12)));
      random_traffic(UNITS_PER_PHASE);
      drain();
    end
    set_timing(DASH_UNITS_RESET, LETTER_GAP_UNITS_RESET, WORD_GAP_UNITS_RESET);
    random_traffic(UNITS_PER_PHASE);
    drain();

    if (errors == 0 && pending == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
